/* rtl/core/ehcw_pkg.sv */
// Package: shared types, protocol codes and sizes for the IPv6 extension header chain walker
package ehcw_pkg;

  localparam int unsigned MIN_HEADER_BYTES = 8;
  // Saturation value of the bytes-since-boundary counter
  localparam int unsigned COUNT_SAT = MIN_HEADER_BYTES + 1;
  localparam int unsigned BPB_W     = $clog2(COUNT_SAT + 1);

  localparam logic [7:0] PROTO_TCP    = 8'd6;
  localparam logic [7:0] PROTO_UDP    = 8'd17;
  localparam logic [7:0] PROTO_ICMPV6 = 8'd58;
  localparam logic [7:0] PROTO_NONXT  = 8'd59;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_HEADER = 3'b010,
    PH_FINAL  = 3'b100
  } phase_t;

  typedef struct packed {
    logic       start_of_packet;
    logic [7:0] first_proto;
    logic [7:0] data_byte;
    logic       end_of_packet;
  } in_item_t;

  // Registered input item handed to the walker
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

endpackage

/* rtl/core/ehcw_in_if.sv */
// Interface: input byte channel with valid/ready handshake
interface ehcw_in_if;
  logic       valid;
  logic       ready;
  logic       start_of_packet;
  logic [7:0] first_proto;
  logic [7:0] data_byte;
  logic       end_of_packet;

  modport source (output valid, output start_of_packet, output first_proto,
                  output data_byte, output end_of_packet, input ready);
  modport sink   (input valid, input start_of_packet, input first_proto,
                  input data_byte, input end_of_packet, output ready);
endinterface

/* rtl/core/ehcw_out_if.sv */
// Interface: result channel with valid/ready handshake
interface ehcw_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  upper_proto;
  logic [15:0] ext_length;
  logic        chain_valid;

  modport source (output valid, output upper_proto, output ext_length,
                  output chain_valid, input ready);
  modport sink   (input valid, input upper_proto, input ext_length,
                  input chain_valid, output ready);
endinterface

/* rtl/core/ehcw_in_stage.sv */
// Input register: captures one byte per transfer and holds it until the walker takes it
module ehcw_in_stage
  import ehcw_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  ehcw_in_if.sink      in_ch,
  input  logic         take,
  output stage_t       stage
);

  logic     valid_r, valid_nxt;
  in_item_t item_r, item_nxt;
  logic     load;

  assign in_ch.ready = !valid_r || take;
  assign load        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (load) begin
      valid_nxt                = 1'b1;
      item_nxt.start_of_packet = in_ch.start_of_packet;
      item_nxt.first_proto     = in_ch.first_proto;
      item_nxt.data_byte       = in_ch.data_byte;
      item_nxt.end_of_packet   = in_ch.end_of_packet;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule

/* rtl/core/ehcw_walker.sv */
// Chain walker: per-byte header state update and the registered result
module ehcw_walker
  import ehcw_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  stage_t       stage,
  output logic         take,
  ehcw_out_if.source   out_ch
);

  phase_t            phase_r, phase_nxt;
  logic [7:0]        cur_r, cur_nxt;
  logic [11:0]       left_r, left_nxt;
  logic [1:0]        bih_r, bih_nxt;
  logic [15:0]       len_r, len_nxt;
  logic [BPB_W-1:0]  bpb_r, bpb_nxt;

  logic              ovalid_r, ovalid_nxt;
  logic [7:0]        oproto_r, oproto_nxt;
  logic [15:0]       olen_r, olen_nxt;
  logic              ook_r, ook_nxt;

  logic              out_free;
  logic              drop;
  logic              bnd;
  logic              ok;
  logic [11:0]       hsize;

  assign out_free = !ovalid_r || out_ch.ready;
  assign take     = stage.valid && out_free;

  always_comb begin
    phase_nxt  = phase_r;
    cur_nxt    = cur_r;
    left_nxt   = left_r;
    bih_nxt    = bih_r;
    len_nxt    = len_r;
    bpb_nxt    = bpb_r;
    drop       = 1'b0;
    bnd        = 1'b0;
    ok         = 1'b0;
    hsize      = {1'b0, stage.item.data_byte, 3'b000} + 12'd8;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    oproto_nxt = oproto_r;
    olen_nxt   = olen_r;
    ook_nxt    = ook_r;

    if (stage.item.start_of_packet) begin
      cur_nxt  = stage.item.first_proto;
      len_nxt  = 16'd0;
      bih_nxt  = 2'd0;
      left_nxt = 12'd0;
      bpb_nxt  = (stage.item.first_proto == PROTO_NONXT) ? BPB_W'(COUNT_SAT) : '0;
      bnd      = 1'b1;
    end else if (phase_r == PH_IDLE) begin
      drop = 1'b1;
    end else if (phase_r == PH_HEADER && bih_r == 2'd2 && left_r == 12'd0) begin
      bnd = 1'b1;
    end

    // header boundary: no-next-header keeps the earlier bounds count running
    if (bnd) begin
      if (cur_nxt == PROTO_NONXT) begin
        phase_nxt = PH_FINAL;
      end else if (cur_nxt == PROTO_TCP || cur_nxt == PROTO_UDP ||
                   cur_nxt == PROTO_ICMPV6) begin
        phase_nxt = PH_FINAL;
        bpb_nxt   = '0;
      end else begin
        phase_nxt = PH_HEADER;
        bpb_nxt   = '0;
        bih_nxt   = 2'd0;
        left_nxt  = 12'd0;
      end
    end

    if (!drop) begin
      if (bpb_nxt < BPB_W'(COUNT_SAT)) begin
        bpb_nxt = bpb_nxt + BPB_W'(1);
      end

      if (phase_nxt == PH_HEADER) begin
        if (bih_nxt == 2'd0) begin
          cur_nxt = stage.item.data_byte;
          bih_nxt = 2'd1;
        end else if (bih_nxt == 2'd1) begin
          len_nxt  = len_nxt + {4'd0, hsize};
          left_nxt = hsize - 12'd2;
          bih_nxt  = 2'd2;
        end else if (left_nxt != 12'd0) begin
          left_nxt = left_nxt - 12'd1;
        end
      end

      if (stage.item.end_of_packet) begin
        ok = (bpb_nxt >= BPB_W'(COUNT_SAT)) &&
             !(phase_nxt == PH_HEADER && cur_nxt != PROTO_NONXT);
        ovalid_nxt = 1'b1;
        oproto_nxt = (ok && phase_nxt == PH_FINAL) ? cur_nxt : PROTO_NONXT;
        olen_nxt   = len_nxt;
        ook_nxt    = ok;
        phase_nxt  = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      cur_r    <= PROTO_NONXT;
      left_r   <= 12'd0;
      bih_r    <= 2'd0;
      len_r    <= 16'd0;
      bpb_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (take) begin
        phase_r <= phase_nxt;
        cur_r   <= cur_nxt;
        left_r  <= left_nxt;
        bih_r   <= bih_nxt;
        len_r   <= len_nxt;
        bpb_r   <= bpb_nxt;
      end
      ovalid_r <= take ? ovalid_nxt : (ovalid_r && !out_ch.ready);
    end
  end

  // hold the result payload until a new result is loaded
  always_ff @(posedge clk) begin
    if (take) begin
      oproto_r <= oproto_nxt;
      olen_r   <= olen_nxt;
      ook_r    <= ook_nxt;
    end
  end

  assign out_ch.valid       = ovalid_r;
  assign out_ch.upper_proto = oproto_r;
  assign out_ch.ext_length  = olen_r;
  assign out_ch.chain_valid = ook_r;

endmodule

/* rtl/core/ipv6_ext_header_chain_walker.sv */
// Top level: IPv6 extension header chain walker
//
//   channel | dir | handshake          | payload
//   in_ch   | in  | valid/ready        | start_of_packet, first_proto, data_byte, end_of_packet
//   out_ch  | out | valid/ready        | upper_proto, ext_length, chain_valid
//
// One byte per cycle while no result waits on out_ch; each byte passes an input
// register, then one step of the header state logic into the result register.
// The rate is set by the state update shared by all bytes.
// rst_n is synchronous, active low, and returns the walk to idle.
// A result waiting on out_ch stalls the walker for every byte until it transfers;
// in_ch keeps accepting while the input register is free.
module ipv6_ext_header_chain_walker
  import ehcw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  ehcw_in_if.sink     in_ch,
  ehcw_out_if.source  out_ch
);

  stage_t stage;
  logic   take;

  ehcw_in_stage u_in_stage (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .take  (take),
    .stage (stage)
  );

  ehcw_walker u_walker (
    .clk    (clk),
    .rst_n  (rst_n),
    .stage  (stage),
    .take   (take),
    .out_ch (out_ch)
  );

endmodule

/* rtl/core/ehcw_checker.sv */
// Checker: port-level assertions for the chain walker, bound to the top level
module ehcw_checker
  import ehcw_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_upper_proto,
  input logic [15:0] out_ext_length,
  input logic        out_chain_valid
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_upper_proto) &&
    $stable(out_ext_length) && $stable(out_chain_valid))
    else $error("result changed while stalled");

  a_bad_chain_nonxt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_chain_valid |-> out_upper_proto == PROTO_NONXT)
    else $error("invalid chain did not report no-next-header");

  a_good_chain_upper: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_chain_valid |->
      (out_upper_proto == PROTO_TCP || out_upper_proto == PROTO_UDP ||
       out_upper_proto == PROTO_ICMPV6 || out_upper_proto == PROTO_NONXT))
    else $error("valid chain reported a non-final protocol");

  a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("result present straight after reset");

endmodule

bind ipv6_ext_header_chain_walker ehcw_checker u_ehcw_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_upper_proto (out_ch.upper_proto),
  .out_ext_length  (out_ch.ext_length),
  .out_chain_valid (out_ch.chain_valid)
);

/* dv/ipv6_ext_header_chain_walker_tb.sv */
// Testbench for the IPv6 extension header chain walker: directed and random byte streams
`timescale 1ns / 1ps

module ipv6_ext_header_chain_walker_tb;
  import ehcw_pkg::*;

  typedef struct packed {
    logic [7:0]  upper_proto;
    logic [15:0] ext_length;
    logic        chain_valid;
  } chain_result_t;

  logic clk = 1'b0;
  logic rst_n;

  ehcw_in_if  in_ch();
  ehcw_out_if out_ch();

  ipv6_ext_header_chain_walker DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  // Predicted walker state
  phase_t             walk_state;
  logic [7:0]         hdr_proto;
  logic [11:0]        hdr_left;
  logic [1:0]         hdr_pos;
  logic [15:0]        ext_sum;
  logic [BPB_W-1:0]   since_boundary;
  logic               chain_bad;

  chain_result_t chain_results_q[$];

  int  fail_count   = 0;
  int  results_seen = 0;
  int  walked_bytes = 0;
  int  hold_cycles  = 0;
  bit  src_idle     = 1'b1;
  bit  sink_idle    = 1'b1;

  function automatic bit is_upper_layer(input logic [7:0] p);
    return p == PROTO_TCP || p == PROTO_UDP || p == PROTO_ICMPV6;
  endfunction

  function automatic void reset_walker();
    walk_state     = PH_IDLE;
    hdr_proto      = PROTO_NONXT;
    hdr_left       = '0;
    hdr_pos        = '0;
    ext_sum        = '0;
    since_boundary = '0;
    chain_bad      = 1'b0;
  endfunction

  // Header boundary at the current byte; hdr_proto names the header starting here
  function automatic void cross_boundary();
    if (hdr_proto == PROTO_NONXT) begin
      walk_state = PH_FINAL;
    end else if (is_upper_layer(hdr_proto)) begin
      walk_state     = PH_FINAL;
      since_boundary = '0;
    end else begin
      walk_state     = PH_HEADER;
      since_boundary = '0;
      hdr_pos        = '0;
      hdr_left       = '0;
    end
  endfunction

  task automatic walk_byte(input in_item_t it);
    logic [15:0]   hdr_size;
    logic          ok;
    chain_result_t res;
    if (it.start_of_packet) begin
      hdr_proto      = it.first_proto;
      ext_sum        = '0;
      chain_bad      = 1'b0;
      hdr_pos        = '0;
      hdr_left       = '0;
      since_boundary = (it.first_proto == PROTO_NONXT) ? BPB_W'(COUNT_SAT) : '0;
      cross_boundary();
    end else if (walk_state == PH_IDLE) begin
      return;
    end else if (walk_state == PH_HEADER && hdr_pos >= 2 && hdr_left == 0) begin
      cross_boundary();
    end
    walked_bytes++;

    if (since_boundary < COUNT_SAT) since_boundary++;

    if (walk_state == PH_HEADER) begin
      case (hdr_pos)
        2'd0: begin
          hdr_proto = it.data_byte;
          hdr_pos   = 2'd1;
        end
        2'd1: begin
          hdr_size = (16'(it.data_byte) + 16'd1) << 3;
          ext_sum  = ext_sum + hdr_size;
          hdr_left = 12'(hdr_size - 16'd2);
          hdr_pos  = 2'd2;
        end
        default: begin
          if (hdr_left > 0) hdr_left--;
        end
      endcase
    end

    if (!it.end_of_packet) return;

    ok = since_boundary >= COUNT_SAT;
    if (walk_state == PH_HEADER && hdr_proto != PROTO_NONXT) ok = 1'b0;
    res.upper_proto = (ok && walk_state == PH_FINAL) ? hdr_proto : PROTO_NONXT;
    res.ext_length  = ext_sum;
    res.chain_valid = ok;
    chain_results_q.push_back(res);
    chain_bad  = !ok;
    walk_state = PH_IDLE;
  endtask

  function automatic in_item_t item_of(input logic sop, input logic [7:0] fp,
                                       input logic [7:0] db, input logic eop);
    in_item_t it;
    it.start_of_packet = sop;
    it.first_proto     = fp;
    it.data_byte       = db;
    it.end_of_packet   = eop;
    return it;
  endfunction

  // Hold valid across back-to-back transfers; lower it only for a gap
  task automatic send_byte(input in_item_t it);
    if (src_idle && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.start_of_packet <= it.start_of_packet;
    in_ch.first_proto     <= it.first_proto;
    in_ch.data_byte       <= it.data_byte;
    in_ch.end_of_packet   <= it.end_of_packet;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    walk_byte(it);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (chain_results_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin : result_sink
    int n;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        n           = hold_cycles;
        hold_cycles = 0;
        out_ch.ready <= 1'b0;
        repeat (n - 1) @(posedge clk);
      end else if (sink_idle && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 19);
        out_ch.ready <= 1'b0;
        repeat (n - 1) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    chain_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (chain_results_q.size() == 0) begin
        $error("unexpected result: upper_proto %0d, ext_length %0d, chain_valid %0b",
               out_ch.upper_proto, out_ch.ext_length, out_ch.chain_valid);
        fail_count++;
      end else begin
        want = chain_results_q.pop_front();
        if (out_ch.upper_proto !== want.upper_proto) begin
          $error("upper_proto: expected %0d, actual %0d", want.upper_proto, out_ch.upper_proto);
          fail_count++;
        end
        if (out_ch.ext_length !== want.ext_length) begin
          $error("ext_length: expected %0d, actual %0d", want.ext_length, out_ch.ext_length);
          fail_count++;
        end
        if (out_ch.chain_valid !== want.chain_valid) begin
          $error("chain_valid: expected %0b, actual %0b", want.chain_valid, out_ch.chain_valid);
          fail_count++;
        end
      end
    end
  end

  function automatic logic [7:0] pick_ext_proto();
    logic [7:0] p;
    p = 8'($urandom);
    while (is_upper_layer(p) || p == PROTO_NONXT) p = 8'($urandom);
    return p;
  endfunction

  function automatic logic [7:0] pick_final_proto();
    case ($urandom_range(0, 3))
      0:       return PROTO_TCP;
      1:       return PROTO_UDP;
      2:       return PROTO_ICMPV6;
      default: return PROTO_NONXT;
    endcase
  endfunction

  // Mostly well-formed chains with random content; the rest is noise and broken packets
  task automatic send_random_packet();
    in_item_t   pkt[$];
    in_item_t   b;
    logic [7:0] nxt, lenb, first;
    int         n_hdr, kind, cut, n;
    kind = $urandom_range(0, 99);
    if (kind < 75) begin
      n_hdr = $urandom_range(0, 3);
      first = (n_hdr == 0) ? pick_final_proto() : pick_ext_proto();
      for (int h = 0; h < n_hdr; h++) begin
        nxt  = (h == n_hdr - 1) ? pick_final_proto() : pick_ext_proto();
        lenb = ($urandom_range(0, 31) == 0) ? 8'($urandom_range(4, 31)) :
                                              8'($urandom_range(0, 3));
        pkt.push_back(item_of(1'b0, 8'($urandom), nxt, 1'b0));
        pkt.push_back(item_of(1'b0, 8'($urandom), lenb, 1'b0));
        repeat ((int'(lenb) + 1) * 8 - 2)
          pkt.push_back(item_of(1'b0, 8'($urandom), 8'($urandom), 1'b0));
      end
      // payload after the chain only feeds the bounds check
      repeat ($urandom_range(0, 14))
        pkt.push_back(item_of(1'b0, 8'($urandom), 8'($urandom), 1'b0));
      if (pkt.size() == 0) pkt.push_back(item_of(1'b0, 8'($urandom), 8'($urandom), 1'b0));
      if ($urandom_range(0, 7) == 0) begin
        cut = $urandom_range(1, pkt.size());
        while (pkt.size() > cut) void'(pkt.pop_back());
      end
    end else if (kind < 95) begin
      first = ($urandom_range(0, 3) == 0) ? PROTO_NONXT : 8'($urandom);
      n     = $urandom_range(1, 20);
      repeat (n)
        pkt.push_back(item_of($urandom_range(0, 15) == 0, 8'($urandom), 8'($urandom),
                              $urandom_range(0, 15) == 0));
    end else begin
      // stray bytes, usually outside any packet
      repeat ($urandom_range(1, 3))
        send_byte(item_of(1'b0, 8'($urandom), 8'($urandom), 1'($urandom)));
      return;
    end
    b                 = pkt[0];
    b.start_of_packet = 1'b1;
    b.first_proto     = first;
    pkt[0]            = b;
    // leave the end off now and then so the next start restarts the walk
    if ($urandom_range(0, 15) != 0) begin
      b               = pkt[pkt.size() - 1];
      b.end_of_packet = 1'b1;
      pkt[pkt.size() - 1] = b;
    end
    foreach (pkt[i]) send_byte(pkt[i]);
  endtask

  task automatic test_stray_bytes();
    send_byte(item_of(1'b0, 8'hFF, 8'hFF, 1'b1));
    send_byte(item_of(1'b0, 8'h00, 8'h00, 1'b0));
    drain_results();
  endtask

  task automatic test_single_byte_packets();
    send_byte(item_of(1'b1, PROTO_NONXT, 8'h00, 1'b1));
    send_byte(item_of(1'b1, PROTO_TCP, 8'hA5, 1'b1));
    send_byte(item_of(1'b1, PROTO_ICMPV6, 8'h5A, 1'b1));
    drain_results();
  endtask

  task automatic test_restart();
    send_byte(item_of(1'b1, 8'd0, PROTO_TCP, 1'b0));
    send_byte(item_of(1'b1, PROTO_UDP, 8'h00, 1'b0));
    for (int i = 0; i < 8; i++)
      send_byte(item_of(1'b0, 8'($urandom), 8'($urandom), i == 7));
    drain_results();
  endtask

  task automatic test_truncated_headers();
    // longest length byte, cut short on the byte after it
    send_byte(item_of(1'b1, 8'd43, PROTO_NONXT, 1'b0));
    send_byte(item_of(1'b0, 8'h00, 8'hFF, 1'b0));
    send_byte(item_of(1'b0, 8'hFF, 8'h00, 1'b1));
    // 16-byte header naming no next header, cut after its bounds check holds
    send_byte(item_of(1'b1, 8'd0, PROTO_NONXT, 1'b0));
    send_byte(item_of(1'b0, 8'h00, 8'd1, 1'b0));
    for (int i = 0; i < 7; i++)
      send_byte(item_of(1'b0, 8'($urandom), 8'($urandom), i == 6));
    drain_results();
  endtask

  task automatic test_pressure();
    src_idle    = 1'b0;
    sink_idle   = 1'b0;
    hold_cycles = 300;
    repeat (30)
      send_byte(item_of(1'b1, pick_final_proto(), 8'($urandom), 1'b1));
    drain_results();
  endtask

  task automatic test_random_packets(input int min_bytes, input int min_results,
                                     input bit with_idle);
    int w0, r0;
    w0 = walked_bytes;
    r0 = results_seen;
    while (walked_bytes - w0 < min_bytes || results_seen - r0 < min_results) begin
      src_idle  = with_idle && $urandom_range(0, 2) != 0;
      sink_idle = with_idle && $urandom_range(0, 2) != 0;
      send_random_packet();
    end
    drain_results();
  endtask

  initial begin
    in_ch.valid           = 1'b0;
    in_ch.start_of_packet = 1'b0;
    in_ch.first_proto     = '0;
    in_ch.data_byte       = '0;
    in_ch.end_of_packet   = 1'b0;
    rst_n = 1'b0;
    reset_walker();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_stray_bytes();
    test_single_byte_packets();
    test_restart();
    test_truncated_headers();
    test_pressure();
    test_random_packets(220, 8, 1'b1);
    test_random_packets(80, 3, 1'b0);

    if (fail_count == 0) begin
      $display("ipv6_ext_header_chain_walker_tb passed");
    end else begin
      $display("ipv6_ext_header_chain_walker_tb failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("ipv6_ext_header_chain_walker_tb failed");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/ehcw_pkg.sv
rtl/core/ehcw_in_if.sv
rtl/core/ehcw_out_if.sv
rtl/core/ehcw_in_stage.sv
rtl/core/ehcw_walker.sv
rtl/core/ipv6_ext_header_chain_walker.sv
rtl/core/ehcw_checker.sv
dv/ipv6_ext_header_chain_walker_tb.sv
